@@ src/dnsqp_pkg.sv @@
`timescale 1ns / 1ps
package dnsqp_pkg;

  localparam int unsigned MaxNameLen = 1025;
  localparam int unsigned NameLenW = $clog2(MaxNameLen + 64);

  localparam logic [15:0] OptTypeCode = 16'h0029;
  localparam logic [15:0] OptDoFlags = 16'h8000;
  localparam logic [7:0] MaxLabelLen = 8'd63;

  // status codes
  localparam logic [2:0] StOk = 3'd0;
  localparam logic [2:0] StSkipped = 3'd1;
  localparam logic [2:0] StShortHdr = 3'd2;
  localparam logic [2:0] StBadLabel = 3'd3;
  localparam logic [2:0] StNameLong = 3'd4;
  localparam logic [2:0] StTruncName = 3'd5;
  localparam logic [2:0] StTruncQuest = 3'd6;
  localparam logic [2:0] StTruncOpt = 3'd7;

  typedef enum logic [5:0] {
    PhHeader = 6'b000001,
    PhLabLen = 6'b000010,
    PhChars  = 6'b000100,
    PhQuest  = 6'b001000,
    PhOpt    = 6'b010000,
    PhDone   = 6'b100000
  } phase_e;

  // one classified byte handed from the front end to the emitter
  typedef struct packed {
    logic        summary;    // 1: summary result, else name work
    logic        escape;     // name byte needs <XX> form
    logic [7:0]  chr;        // character (already lowercased)
    logic        dot_after;  // a '.' follows this character
    logic        dot_only;   // only a '.' (root name)
    logic [15:0] query_id;
    logic [15:0] header_flags;
    logic [15:0] question_count;
    logic [15:0] answer_count;
    logic [15:0] authority_count;
    logic [15:0] additional_count;
    logic [15:0] query_type;
    logic [15:0] query_class;
    logic        dnssec_ok;
    logic [2:0]  status;
  } work_t;

  localparam int unsigned QueueDepth = 4;
  localparam int unsigned QueuePtrW = $clog2(QueueDepth);

  function automatic logic [7:0] hex_digit(input logic [3:0] v);
    logic [7:0] r;
    if (v < 4'd10) begin
      r = 8'h30 + {4'd0, v};
    end else begin
      r = 8'h37 + {4'd0, v};
    end
    return r;
  endfunction

endpackage

@@ src/dns_question_parser.sv @@
`timescale 1ns / 1ps
// channel   ports                                          transfer
// input     data_byte_i last_byte_i skip_packet_i          push & !full
// result    kind_o name_char_o header fields status_o      pop & !empty
//
// one byte a cycle in while full is low; a name byte gives 1 to 5 characters,
// one per cycle while the output register can take them, set by the output
// stepper in the back end. a byte's results pass the queue, then the output register.
// full rises when fewer than two of the 4 queue entries are free.
// rst_ni clears all parse state and the queue; no clearing pass.
// a result waiting in the output register stalls the back end; input stalls
// only once the queue fills.
module dns_question_parser
  import dnsqp_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push,
  output logic        full,
  input  logic [7:0]  data_byte_i,
  input  logic        last_byte_i,
  input  logic        skip_packet_i,
  output logic        empty,
  input  logic        pop,
  output logic        kind_o,
  output logic [7:0]  name_char_o,
  output logic [15:0] query_id_o,
  output logic [15:0] header_flags_o,
  output logic [15:0] question_count_o,
  output logic [15:0] answer_count_o,
  output logic [15:0] authority_count_o,
  output logic [15:0] additional_count_o,
  output logic [15:0] query_type_o,
  output logic [15:0] query_class_o,
  output logic        dnssec_ok_o,
  output logic [2:0]  status_o
);

  logic  room, acc, wr, wr2, avail, rd;
  work_t wdata, wdata2, rdata;

  assign full = !room;
  assign acc = push && room;

  dnsqp_front u_front (
    .clk_i, .rst_ni,
    .valid_i(acc), .data_byte_i, .last_byte_i, .skip_packet_i,
    .wr_o(wr), .work_o(wdata), .work2_o(wr2), .work2_data_o(wdata2)
  );

  dnsqp_queue u_queue (
    .clk_i, .rst_ni,
    .wr_i(wr), .wdata_i(wdata), .wr2_i(wr2), .wdata2_i(wdata2),
    .room_o(room), .rd_i(rd), .avail_o(avail), .rdata_o(rdata)
  );

  dnsqp_back u_back (
    .clk_i, .rst_ni,
    .avail_i(avail), .work_i(rdata), .rd_o(rd),
    .empty_o(empty), .pop_i(pop),
    .kind_o, .name_char_o, .query_id_o, .header_flags_o, .question_count_o,
    .answer_count_o, .authority_count_o, .additional_count_o,
    .query_type_o, .query_class_o, .dnssec_ok_o, .status_o
  );

`ifndef ASSERT_OFF
  a_name_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty && kind_o |-> name_char_o == 8'h00) else $error("summary char");
  a_read_needs_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rd |-> avail) else $error("queue underrun");
  a_no_write_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr |-> room) else $error("queue overrun");
`endif

endmodule

@@ src/dnsqp_front.sv @@
`timescale 1ns / 1ps
module dnsqp_front
  import dnsqp_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       valid_i,
  input  logic [7:0] data_byte_i,
  input  logic       last_byte_i,
  input  logic       skip_packet_i,
  output logic       wr_o,
  output work_t      work_o,
  output logic       work2_o,
  output work_t      work2_data_o
);

  phase_e             phase_q, phase_d;
  logic [3:0]         pos_q, pos_d;
  logic [5:0]         left_q, left_d;
  logic [NameLenW-1:0] nlen_q, nlen_d;
  logic [15:0]        hw_q [6];
  logic [15:0]        hw_d [6];
  logic [15:0]        qt_q, qt_d, qc_q, qc_d, ot_q, ot_d, of_q, of_d;
  logic               dnssec_q, dnssec_d;
  logic [2:0]         stat_q, stat_d;

  work_t name_w, sum_w;
  logic  name_v;
  logic [2:0] st_fin;
  logic [NameLenW-1:0] b_ext;

  assign b_ext = NameLenW'(data_byte_i);

  // per-byte parsing
  always_comb begin
    phase_d = phase_q;
    pos_d = pos_q;
    left_d = left_q;
    nlen_d = nlen_q;
    hw_d = hw_q;
    qt_d = qt_q;
    qc_d = qc_q;
    ot_d = ot_q;
    of_d = of_q;
    dnssec_d = dnssec_q;
    stat_d = stat_q;
    name_v = 1'b0;
    name_w = '0;
    unique case (phase_q)
      PhHeader: begin
        if (pos_q == 4'd0 && skip_packet_i) begin
          stat_d = StSkipped;
          phase_d = PhDone;
        end else begin
          if (!pos_q[0]) begin
            hw_d[pos_q[3:1]] = {data_byte_i, 8'h00};
          end else begin
            hw_d[pos_q[3:1]] = hw_q[pos_q[3:1]] | {8'h00, data_byte_i};
          end
          pos_d = pos_q + 4'd1;
          if (pos_q == 4'd11) begin
            pos_d = '0;
            phase_d = PhLabLen;
          end
        end
      end
      PhLabLen: begin
        if (data_byte_i == 8'd0) begin
          if (nlen_q == '0) begin
            name_v = 1'b1;
            name_w.dot_only = 1'b1;
          end
          nlen_d = nlen_q + NameLenW'(1);
          pos_d = '0;
          phase_d = PhQuest;
        end else if (data_byte_i > MaxLabelLen) begin
          stat_d = StBadLabel;
          phase_d = PhDone;
        end else if (nlen_q + b_ext > NameLenW'(MaxNameLen)) begin
          stat_d = StNameLong;
          phase_d = PhDone;
        end else begin
          left_d = data_byte_i[5:0];
          nlen_d = nlen_q + b_ext + NameLenW'(1);
          phase_d = PhChars;
        end
      end
      PhChars: begin
        name_v = 1'b1;
        name_w.escape = (data_byte_i <= 8'h20) || (data_byte_i == 8'h7f);
        if (data_byte_i >= 8'h41 && data_byte_i <= 8'h5a) begin
          name_w.chr = data_byte_i + 8'h20;
        end else begin
          name_w.chr = data_byte_i;
        end
        left_d = (left_q != '0) ? left_q - 6'd1 : left_q;
        if (left_d == '0) begin
          name_w.dot_after = 1'b1;
          phase_d = PhLabLen;
        end
      end
      PhQuest: begin
        if (pos_q == 4'd0) qt_d = {data_byte_i, 8'h00};
        else if (pos_q == 4'd1) qt_d = qt_q | {8'h00, data_byte_i};
        else if (pos_q == 4'd2) qc_d = {data_byte_i, 8'h00};
        else qc_d = qc_q | {8'h00, data_byte_i};
        pos_d = pos_q + 4'd1;
        if (pos_q == 4'd3) begin
          pos_d = '0;
          phase_d = (hw_q[5] != 16'd0) ? PhOpt : PhDone;
        end
      end
      PhOpt: begin
        if (pos_q == 4'd1) ot_d = {data_byte_i, 8'h00};
        else if (pos_q == 4'd2) ot_d = ot_q | {8'h00, data_byte_i};
        else if (pos_q == 4'd7) of_d = {data_byte_i, 8'h00};
        else if (pos_q == 4'd8) of_d = of_q | {8'h00, data_byte_i};
        pos_d = pos_q + 4'd1;
        if (pos_q == 4'd10) begin
          dnssec_d = (ot_q == OptTypeCode) && (of_q == OptDoFlags);
          pos_d = '0;
          phase_d = PhDone;
        end
      end
      PhDone: begin
      end
      default: begin
        phase_d = PhHeader;
      end
    endcase
  end

  // summary built from the next-state view
  always_comb begin
    st_fin = stat_d;
    if (stat_d == StOk) begin
      priority case (1'b1)
        phase_d == PhHeader: st_fin = StShortHdr;
        phase_d == PhLabLen || phase_d == PhChars: st_fin = StTruncName;
        phase_d == PhQuest: st_fin = StTruncQuest;
        phase_d == PhOpt: st_fin = StTruncOpt;
        default: st_fin = StOk;
      endcase
    end
    sum_w = '0;
    sum_w.summary = 1'b1;
    sum_w.query_id = hw_d[0];
    sum_w.header_flags = hw_d[1];
    sum_w.question_count = hw_d[2];
    sum_w.answer_count = hw_d[3];
    sum_w.authority_count = hw_d[4];
    sum_w.additional_count = hw_d[5];
    sum_w.query_type = qt_d;
    sum_w.query_class = qc_d;
    sum_w.dnssec_ok = dnssec_d;
    sum_w.status = st_fin;
  end

  // queue writes: name work first, summary after it
  always_comb begin
    wr_o = 1'b0;
    work_o = name_w;
    work2_o = 1'b0;
    work2_data_o = sum_w;
    if (valid_i) begin
      if (name_v) begin
        wr_o = 1'b1;
        work2_o = last_byte_i;
      end else if (last_byte_i) begin
        wr_o = 1'b1;
        work_o = sum_w;
      end
    end
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PhHeader;
      pos_q <= '0;
      left_q <= '0;
      nlen_q <= '0;
      stat_q <= StOk;
      dnssec_q <= 1'b0;
      for (int i = 0; i < 6; i++) hw_q[i] <= '0;
      qt_q <= '0;
      qc_q <= '0;
      ot_q <= '0;
      of_q <= '0;
    end else if (valid_i) begin
      if (last_byte_i) begin
        phase_q <= PhHeader;
        pos_q <= '0;
        left_q <= '0;
        nlen_q <= '0;
        stat_q <= StOk;
        dnssec_q <= 1'b0;
        for (int i = 0; i < 6; i++) hw_q[i] <= '0;
        qt_q <= '0;
        qc_q <= '0;
        ot_q <= '0;
        of_q <= '0;
      end else begin
        phase_q <= phase_d;
        pos_q <= pos_d;
        left_q <= left_d;
        nlen_q <= nlen_d;
        stat_q <= stat_d;
        dnssec_q <= dnssec_d;
        hw_q <= hw_d;
        qt_q <= qt_d;
        qc_q <= qc_d;
        ot_q <= ot_d;
        of_q <= of_d;
      end
    end
  end

endmodule

@@ src/dnsqp_queue.sv @@
`timescale 1ns / 1ps
module dnsqp_queue
  import dnsqp_pkg::*;
(
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  wr_i,
  input  work_t wdata_i,
  input  logic  wr2_i,
  input  work_t wdata2_i,
  output logic  room_o,
  input  logic  rd_i,
  output logic  avail_o,
  output work_t rdata_o
);

  work_t                mem_q [QueueDepth];
  logic [QueuePtrW-1:0] wp_q, rp_q;
  logic [QueuePtrW:0]   cnt_q;
  logic [QueuePtrW-1:0] wp1;
  logic [QueuePtrW:0]   n_wr;

  assign wp1 = wp_q + QueuePtrW'(1);
  assign n_wr = (QueuePtrW+1)'(wr_i) + (QueuePtrW+1)'(wr2_i);
  // two free entries keep a double write safe
  assign room_o = cnt_q <= (QueuePtrW+1)'(QueueDepth - 2);
  assign avail_o = cnt_q != '0;
  assign rdata_o = mem_q[rp_q];

  // entry storage
  always_ff @(posedge clk_i) begin
    if (wr_i) mem_q[wp_q] <= wdata_i;
    if (wr2_i) mem_q[wp1] <= wdata2_i;
  end

  // pointers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= '0;
      rp_q <= '0;
      cnt_q <= '0;
    end else begin
      wp_q <= wp_q + n_wr[QueuePtrW-1:0];
      if (rd_i) rp_q <= rp_q + QueuePtrW'(1);
      cnt_q <= cnt_q + n_wr - (QueuePtrW+1)'(rd_i);
    end
  end

endmodule

@@ src/dnsqp_back.sv @@
`timescale 1ns / 1ps
module dnsqp_back
  import dnsqp_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        avail_i,
  input  work_t       work_i,
  output logic        rd_o,
  output logic        empty_o,
  input  logic        pop_i,
  output logic        kind_o,
  output logic [7:0]  name_char_o,
  output logic [15:0] query_id_o,
  output logic [15:0] header_flags_o,
  output logic [15:0] question_count_o,
  output logic [15:0] answer_count_o,
  output logic [15:0] authority_count_o,
  output logic [15:0] additional_count_o,
  output logic [15:0] query_type_o,
  output logic [15:0] query_class_o,
  output logic        dnssec_ok_o,
  output logic [2:0]  status_o
);

  // step through the characters of one work item
  logic [2:0] step_q, step_d;
  logic [2:0] nsteps;
  logic       ov_q;
  logic       take;
  logic       done_item;
  work_t      res;

  always_comb begin
    if (work_i.summary || work_i.dot_only) nsteps = 3'd1;
    else if (work_i.escape) nsteps = work_i.dot_after ? 3'd5 : 3'd4;
    else nsteps = work_i.dot_after ? 3'd2 : 3'd1;
  end

  assign take = avail_i && (!ov_q || pop_i);
  assign done_item = step_q == nsteps - 3'd1;
  assign rd_o = take && done_item;
  assign step_d = done_item ? 3'd0 : step_q + 3'd1;

  // character selection
  always_comb begin
    res = work_i;
    if (!work_i.summary) begin
      res = '0;
      if (work_i.dot_only) begin
        res.chr = 8'h2e;
      end else if (work_i.escape) begin
        unique case (step_q)
          3'd0: res.chr = 8'h3c;
          3'd1: res.chr = hex_digit(work_i.chr[7:4]);
          3'd2: res.chr = hex_digit(work_i.chr[3:0]);
          3'd3: res.chr = 8'h3e;
          default: res.chr = 8'h2e;
        endcase
      end else begin
        res.chr = (step_q == 3'd0) ? work_i.chr : 8'h2e;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= '0;
      ov_q <= 1'b0;
    end else begin
      if (take) step_q <= step_d;
      if (take) ov_q <= 1'b1;
      else if (pop_i) ov_q <= 1'b0;
    end
  end

  // output register
  always_ff @(posedge clk_i) begin
    if (take) begin
      kind_o <= res.summary;
      name_char_o <= res.summary ? 8'h00 : res.chr;
      query_id_o <= res.query_id;
      header_flags_o <= res.header_flags;
      question_count_o <= res.question_count;
      answer_count_o <= res.answer_count;
      authority_count_o <= res.authority_count;
      additional_count_o <= res.additional_count;
      query_type_o <= res.query_type;
      query_class_o <= res.query_class;
      dnssec_ok_o <= res.dnssec_ok;
      status_o <= res.status;
    end
  end

  assign empty_o = !ov_q;

endmodule

@@ tb/dns_question_parser_test.sv @@
`timescale 1ns / 1ps
module dns_question_parser_test;
  import dnsqp_pkg::*;

  localparam int unsigned CycleLimit = 600000;
  localparam int unsigned RandomBytes = 370;

  // one parser result as seen on the output ports
  typedef struct packed {
    logic            kind;
    logic [7:0]      name_char;
    logic [5:0][15:0] hdr;
    logic [15:0]     qtype;
    logic [15:0]     qclass;
    logic            dnssec;
    logic [2:0]      status;
  } parse_result_t;

  // directed stimulus row, with a typed status where the summary is obvious
  typedef struct packed {
    logic [7:0] data;
    logic       last;
    logic       skip;
    logic       chk;
    logic [2:0] status;
  } dir_row_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        push = 1'b0;
  logic        full;
  logic [7:0]  data_byte_i = 8'h00;
  logic        last_byte_i = 1'b0;
  logic        skip_packet_i = 1'b0;
  logic        empty;
  logic        pop = 1'b0;
  logic        kind_o;
  logic [7:0]  name_char_o;
  logic [15:0] query_id_o, header_flags_o, question_count_o, answer_count_o;
  logic [15:0] authority_count_o, additional_count_o, query_type_o, query_class_o;
  logic        dnssec_ok_o;
  logic [2:0]  status_o;

  dns_question_parser i_dut (.*);

  always #6 clk_i = ~clk_i;

  // parser shadow state
  phase_e       ph;
  int unsigned  pos, lab_left, name_len;
  logic [5:0][15:0] hdr_w;
  logic [15:0]  q_type, q_class, opt_type, opt_flags;
  logic         dnssec;
  logic [2:0]   st_code;

  parse_result_t parse_results_q[$];
  parse_result_t last_summary;
  int unsigned   fail_count = 0;
  int unsigned   cycles = 0;
  int unsigned   rx_count = 0;
  logic          row_chk = 1'b0;
  logic [2:0]    row_status = StOk;
  logic          no_idle = 1'b0;
  logic [7:0]    pkt_bytes[$];
  logic          pkt_skip;

  function void clear_parse();
    ph = PhHeader;
    pos = 0;
    lab_left = 0;
    name_len = 0;
    hdr_w = '0;
    q_type = '0;
    q_class = '0;
    opt_type = '0;
    opt_flags = '0;
    dnssec = 1'b0;
    st_code = StOk;
  endfunction

  function void add_char(logic [7:0] c);
    parse_result_t r;
    r = '0;
    r.name_char = c;
    parse_results_q.insert(parse_results_q.size(), r);
  endfunction

  function logic [7:0] hex_chr(logic [3:0] v);
    return (v < 4'd10) ? 8'h30 + 8'(v) : 8'h41 + 8'(v - 4'd10);
  endfunction

  function automatic void set_half(ref logic [15:0] w, input int unsigned p,
                                   input logic [7:0] b);
    if (p % 2 == 0) w = {b, 8'h00};
    else w[7:0] = b;
  endfunction

  // predict results for one accepted message byte
  function void parse_byte(logic [7:0] b, logic last, logic skip);
    parse_result_t r;
    logic [15:0] w;
    case (ph)
      PhHeader: begin
        if (pos == 0 && skip) begin
          st_code = StSkipped;
          ph = PhDone;
        end else begin
          w = hdr_w[pos / 2];
          set_half(w, pos, b);
          hdr_w[pos / 2] = w;
          pos++;
          if (pos >= 12) begin
            pos = 0;
            ph = PhLabLen;
          end
        end
      end
      PhLabLen: begin
        if (b == 8'h00) begin
          if (name_len == 0) add_char(8'h2E);
          name_len++;
          pos = 0;
          ph = PhQuest;
        end else if (b > MaxLabelLen) begin
          st_code = StBadLabel;
          ph = PhDone;
        end else if (name_len + b > MaxNameLen) begin
          st_code = StNameLong;
          ph = PhDone;
        end else begin
          lab_left = b;
          name_len += b + 1;
          ph = PhChars;
        end
      end
      PhChars: begin
        if (b <= 8'h20 || b == 8'h7F) begin
          add_char(8'h3C);
          add_char(hex_chr(b[7:4]));
          add_char(hex_chr(b[3:0]));
          add_char(8'h3E);
        end else if (b >= 8'h41 && b <= 8'h5A) begin
          add_char(b + 8'h20);
        end else begin
          add_char(b);
        end
        if (lab_left > 0) lab_left--;
        if (lab_left == 0) begin
          add_char(8'h2E);
          ph = PhLabLen;
        end
      end
      PhQuest: begin
        if (pos < 2) set_half(q_type, pos, b);
        else set_half(q_class, pos, b);
        pos++;
        if (pos >= 4) begin
          pos = 0;
          ph = (hdr_w[5] != 0) ? PhOpt : PhDone;
        end
      end
      PhOpt: begin
        if (pos == 1 || pos == 2) set_half(opt_type, pos - 1, b);
        else if (pos == 7 || pos == 8) set_half(opt_flags, pos - 7, b);
        pos++;
        if (pos >= 11) begin
          dnssec = (opt_type == OptTypeCode && opt_flags == OptDoFlags);
          pos = 0;
          ph = PhDone;
        end
      end
      default: ;
    endcase
    // summary closes the message
    if (last) begin
      r = '0;
      r.kind = 1'b1;
      r.hdr = hdr_w;
      r.qtype = q_type;
      r.qclass = q_class;
      r.dnssec = dnssec;
      r.status = st_code;
      if (st_code == StOk) begin
        case (ph)
          PhHeader: r.status = StShortHdr;
          PhLabLen, PhChars: r.status = StTruncName;
          PhQuest: r.status = StTruncQuest;
          PhOpt: r.status = StTruncOpt;
          default: ;
        endcase
      end
      parse_results_q.insert(parse_results_q.size(), r);
      last_summary = r;
      clear_parse();
    end
  endfunction

  function void check_field(string name, longint unsigned exp_v, longint unsigned act_v);
    if (exp_v != act_v) begin
      $error("%s: expected %0h, actual %0h", name, exp_v, act_v);
      fail_count++;
    end
  endfunction

  // monitor: predict on input transfer, compare on result transfer
  always @(posedge clk_i) begin
    parse_result_t e;
    if (rst_ni) begin
      if (push && !full) begin
        parse_byte(data_byte_i, last_byte_i, skip_packet_i);
        if (row_chk) check_field("status (typed)", row_status, last_summary.status);
      end
      if (pop && !empty) begin
        if (parse_results_q.size() == 0) begin
          $error("result transfer with nothing expected");
          fail_count++;
        end else begin
          e = parse_results_q.pop_front();
          check_field("kind", e.kind, kind_o);
          check_field("name_char", e.name_char, name_char_o);
          check_field("query_id", e.hdr[0], query_id_o);
          check_field("header_flags", e.hdr[1], header_flags_o);
          check_field("question_count", e.hdr[2], question_count_o);
          check_field("answer_count", e.hdr[3], answer_count_o);
          check_field("authority_count", e.hdr[4], authority_count_o);
          check_field("additional_count", e.hdr[5], additional_count_o);
          check_field("query_type", e.qtype, query_type_o);
          check_field("query_class", e.qclass, query_class_o);
          check_field("dnssec_ok", e.dnssec, dnssec_ok_o);
          check_field("status", e.status, status_o);
        end
      end
    end
  end

  // run limit
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // drive one byte and wait for its transfer
  task send_byte(logic [7:0] d, logic l, logic s, logic chk, logic [2:0] exp_st);
    int unsigned gap;
    gap = no_idle ? 0 : $urandom_range(0, 7);
    repeat (gap) begin
      @(negedge clk_i);
      push <= 1'b0;
    end
    @(negedge clk_i);
    push <= 1'b1;
    data_byte_i <= d;
    last_byte_i <= l;
    skip_packet_i <= s;
    row_chk <= chk;
    row_status <= exp_st;
    do @(posedge clk_i); while (full);
  endtask

  function logic [7:0] name_byte();
    int unsigned sel;
    sel = $urandom_range(0, 99);
    if (sel < 30) return 8'($urandom_range(8'h41, 8'h5A));
    if (sel < 40) return 8'($urandom_range(0, 8'h20));
    if (sel < 45) return 8'h7F;
    return 8'($urandom_range(0, 255));
  endfunction

  // build one message; long_name asks for a name past the length limit
  task build_packet(logic long_name);
    int unsigned nlab, len, cut;
    logic [15:0] arcount;
    pkt_bytes.delete();
    pkt_skip = ($urandom_range(0, 19) == 0);
    arcount = ($urandom_range(0, 1) == 0) ? 16'h0000 : 16'($urandom_range(1, 65535));
    repeat (10) pkt_bytes.insert(pkt_bytes.size(), 8'($urandom_range(0, 255)));
    pkt_bytes.insert(pkt_bytes.size(), arcount[15:8]);
    pkt_bytes.insert(pkt_bytes.size(), arcount[7:0]);
    nlab = long_name ? 17 : $urandom_range(0, 4);
    for (int i = 0; i < nlab; i++) begin
      if (long_name) len = (i < 16) ? 63 : 2;
      else if ($urandom_range(0, 19) == 0) len = $urandom_range(64, 255);
      else if ($urandom_range(0, 19) == 0) len = 63;
      else len = $urandom_range(1, 10);
      pkt_bytes.insert(pkt_bytes.size(), 8'(len));
      if (len <= 63) repeat (len) pkt_bytes.insert(pkt_bytes.size(), name_byte());
    end
    pkt_bytes.insert(pkt_bytes.size(), 8'h00);
    repeat (4) pkt_bytes.insert(pkt_bytes.size(), 8'($urandom_range(0, 255)));
    if (arcount != 0) begin
      for (int i = 0; i < 11; i++) begin
        if (i == 1)
          pkt_bytes.insert(pkt_bytes.size(),
                           $urandom_range(0, 9) < 7 ? 8'h00 : 8'($urandom));
        else if (i == 2)
          pkt_bytes.insert(pkt_bytes.size(),
                           $urandom_range(0, 9) < 7 ? 8'h29 : 8'($urandom));
        else if (i == 7)
          pkt_bytes.insert(pkt_bytes.size(),
                           $urandom_range(0, 9) < 6 ? 8'h80 : 8'($urandom));
        else if (i == 8)
          pkt_bytes.insert(pkt_bytes.size(),
                           $urandom_range(0, 9) < 6 ? 8'h00 : 8'($urandom));
        else pkt_bytes.insert(pkt_bytes.size(), 8'($urandom_range(0, 255)));
      end
    end
    if ($urandom_range(0, 3) == 0)
      repeat ($urandom_range(1, 3)) pkt_bytes.insert(pkt_bytes.size(), 8'($urandom));
    // truncated message
    if (!long_name && $urandom_range(0, 6) == 0) begin
      cut = $urandom_range(1, pkt_bytes.size());
      while (pkt_bytes.size() > cut) void'(pkt_bytes.pop_back());
    end
  endtask

  // result side: random stalls, one long hold-off to fill the block
  initial begin
    int unsigned gap;
    forever begin
      gap = no_idle ? 0 : $urandom_range(0, 7);
      repeat (gap) begin
        @(negedge clk_i);
        pop <= 1'b0;
      end
      @(negedge clk_i);
      pop <= 1'b1;
      do @(posedge clk_i); while (empty);
      rx_count++;
      if (rx_count == 60) begin
        @(negedge clk_i);
        pop <= 1'b0;
        repeat (400) @(negedge clk_i);
      end
    end
  end

  initial begin
    dir_row_t rows[$];
    int unsigned sent;
    clear_parse();
    // skipped message, short header, root-name query
    rows.insert(rows.size(), '{8'hFF, 1'b1, 1'b1, 1'b1, StSkipped});
    rows.insert(rows.size(), '{8'h00, 1'b0, 1'b0, 1'b0, StOk});
    rows.insert(rows.size(), '{8'hFF, 1'b1, 1'b0, 1'b1, StShortHdr});
    rows.insert(rows.size(), '{8'hFF, 1'b0, 1'b0, 1'b0, StOk});
    rows.insert(rows.size(), '{8'hFF, 1'b0, 1'b1, 1'b0, StOk});
    repeat (2) rows.insert(rows.size(), '{8'h00, 1'b0, 1'b0, 1'b0, StOk});
    rows.insert(rows.size(), '{8'h00, 1'b0, 1'b0, 1'b0, StOk});
    rows.insert(rows.size(), '{8'h01, 1'b0, 1'b0, 1'b0, StOk});
    repeat (6) rows.insert(rows.size(), '{8'h00, 1'b0, 1'b0, 1'b0, StOk});
    rows.insert(rows.size(), '{8'h00, 1'b0, 1'b0, 1'b0, StOk});
    rows.insert(rows.size(), '{8'h00, 1'b0, 1'b0, 1'b0, StOk});
    rows.insert(rows.size(), '{8'h01, 1'b0, 1'b0, 1'b0, StOk});
    rows.insert(rows.size(), '{8'h00, 1'b0, 1'b0, 1'b0, StOk});
    rows.insert(rows.size(), '{8'hFF, 1'b1, 1'b0, 1'b1, StOk});

    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    foreach (rows[i]) send_byte(rows[i].data, rows[i].last, rows[i].skip, rows[i].chk,
                                rows[i].status);
    // sender pause until the block drains
    @(negedge clk_i);
    push <= 1'b0;
    row_chk <= 1'b0;
    while (parse_results_q.size() != 0) @(posedge clk_i);

    sent = 0;
    for (int p = 0; sent < RandomBytes || p < 8; p++) begin
      build_packet(1'b0);
      no_idle = ($urandom_range(0, 3) == 0);
      foreach (pkt_bytes[i]) begin
        send_byte(pkt_bytes[i], i == pkt_bytes.size() - 1,
                  (i == 0) ? pkt_skip : 1'($urandom), 1'b0, StOk);
        sent++;
      end
    end
    @(negedge clk_i);
    push <= 1'b0;
    no_idle = 1'b0;

    while (parse_results_q.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
